// ===== rtl/sacr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sacr_pkg;

    localparam int ENTRIES = 256;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 31;
    localparam int NU_W    = 31;
    localparam int BYTES_W = 40;
    localparam int EVC_W   = 9;
    localparam int ENTRY_W = KEY_W + SIZE_W + NU_W;
    localparam int IN_W    = 96;
    localparam int OUT_W   = 136;
    localparam int USER_W  = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        logic [NU_W-1:0]   nu;
    } entry_t;

    typedef struct packed {
        logic              hit_found;
        logic [IDX_W-1:0]  hit_idx;
        logic [SIZE_W-1:0] hit_size;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
        logic              best_found;
        logic [IDX_W-1:0]  best_idx;
        logic [NU_W-1:0]   best_nu;
        logic [SIZE_W-1:0] best_size;
    } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/sacr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sacr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sacr_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sacr_scan (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       clear,
    input  wire logic                       chk,
    input  wire logic [sacr_pkg::IDX_W-1:0] idx,
    input  wire logic                       slot_valid,
    input  wire sacr_pkg::entry_t           entry,
    input  wire logic [sacr_pkg::KEY_W-1:0] key,
    output sacr_pkg::scan_res_t             res
);
    import sacr_pkg::*;

    scan_res_t res_reg;
    scan_res_t res_next;

    always_comb begin
        res_next = res_reg;
        if (clear) begin
            res_next.hit_found  = 1'b0;
            res_next.free_found = 1'b0;
            res_next.best_found = 1'b0;
        end else if (chk) begin
            if (slot_valid) begin
                if (!res_reg.hit_found && entry.key == key) begin
                    res_next.hit_found = 1'b1;
                    res_next.hit_idx   = idx;
                    res_next.hit_size  = entry.size;
                end
                // strict compare keeps the lowest slot on ties
                if (!res_reg.best_found || entry.nu > res_reg.best_nu) begin
                    res_next.best_found = 1'b1;
                    res_next.best_idx   = idx;
                    res_next.best_nu    = entry.nu;
                    res_next.best_size  = entry.size;
                end
            end else if (!res_reg.free_found) begin
                res_next.free_found = 1'b1;
                res_next.free_idx   = idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg <= '0;
        end else begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== rtl/size_aware_min_cache_replacement_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// size-aware optimal replacement for a simulated cache of ENTRIES slots.
// requests arrive on the s_ channel (key, size, next use), one result per
// request leaves on the m_ channel. the user must write capacity_bytes on the
// cfg channel only while the block is idle; the block itself does not enforce
// it. cfg_ready is always high. each request sweeps the slot table through a
// single read port, checking for a hit, the lowest free slot and the farthest
// next use in the same pass, then decides. one extra sweep follows every
// eviction, and the result is published after the last sweep; the next
// request can be taken once the block is back in idle.
// s_tready is high only between requests; the result sits in an output
// register, so the next request is taken while it waits, and the block
// holds before publishing a new result until the old one is taken.
// reset clears all slot valid bits, the byte total, both counters and
// capacity; the table contents need no clearing pass.
module size_aware_min_cache_replacement_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sacr_pkg::BYTES_W-1:0]  cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // object_key, object_size, next_use
    input  wire logic [sacr_pkg::IN_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // evicted_count, bytes_used, total_requests, hit_total
    output logic      [sacr_pkg::OUT_W-1:0]    m_tdata,
    // hit, bypassed
    output logic      [sacr_pkg::USER_W-1:0]   m_tuser
);
    import sacr_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [NU_W-1:0]     nu_reg, nu_next;
    logic [BYTES_W-1:0]  cap_reg, cap_next;
    logic [BYTES_W-1:0]  resident_reg, resident_next;
    logic [BYTES_W-1:0]  req_reg, req_next;
    logic [BYTES_W-1:0]  hits_reg, hits_next;
    logic [EVC_W-1:0]    evc_reg, evc_next;
    logic                hit_reg, hit_next;
    logic                byp_reg, byp_next;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_data_reg, m_data_next;
    logic [USER_W-1:0]   m_user_reg, m_user_next;

    logic                scan_clear;
    scan_res_t           res;
    entry_t              rd_entry;
    logic [ENTRY_W-1:0]  rd_data;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    entry_t              wr_entry;
    logic [BYTES_W:0]    need_bytes;
    logic                too_big;
    logic                fits;

    sacr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    assign rd_entry = entry_t'(rd_data);

    sacr_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .clear      (scan_clear),
        .chk        (chk_vld_reg),
        .idx        (chk_idx_reg),
        .slot_valid (valid_reg[chk_idx_reg]),
        .entry      (rd_entry),
        .key        (key_reg),
        .res        (res)
    );

    assign need_bytes = {1'b0, resident_reg} + (BYTES_W + 1)'(size_reg);
    assign too_big    = BYTES_W'(size_reg) > cap_reg;
    assign fits       = need_bytes <= {1'b0, cap_reg};

    assign cfg_ready = 1'b1;
    assign s_tready  = state_reg == ST_IDLE;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = chk_idx_reg;
        key_next      = key_reg;
        size_next     = size_reg;
        nu_next       = nu_reg;
        cap_next      = cap_reg;
        resident_next = resident_reg;
        req_next      = req_reg;
        hits_next     = hits_reg;
        evc_next      = evc_reg;
        hit_next      = hit_reg;
        byp_next      = byp_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        scan_clear    = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = res.free_idx;
        wr_entry      = '{key: key_reg, size: size_reg, nu: nu_reg};

        if (cfg_valid && cfg_ready) begin
            cap_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    key_next   = s_tdata[KEY_W-1:0];
                    size_next  = s_tdata[KEY_W+SIZE_W-1:KEY_W];
                    nu_next    = s_tdata[ENTRY_W-1:KEY_W+SIZE_W];
                    cnt_next   = '0;
                    evc_next   = '0;
                    hit_next   = 1'b0;
                    byp_next   = 1'b0;
                    scan_clear = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg < CNT_W'(ENTRIES)) begin
                    chk_vld_next = 1'b1;
                    chk_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next     = cnt_reg + CNT_W'(1);
                end else if (!chk_vld_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (res.hit_found) begin
                    // keep the stored size, refresh next use only
                    wr_en         = 1'b1;
                    wr_addr       = res.hit_idx;
                    wr_entry.size = res.hit_size;
                    hit_next      = 1'b1;
                    hits_next     = hits_reg + BYTES_W'(1);
                    state_next    = ST_FINISH;
                end else if (too_big) begin
                    byp_next   = 1'b1;
                    state_next = ST_FINISH;
                end else if ((!fits || !res.free_found) && res.best_found) begin
                    valid_next[res.best_idx] = 1'b0;
                    resident_next = resident_reg - BYTES_W'(res.best_size);
                    evc_next      = evc_reg + EVC_W'(1);
                    cnt_next      = '0;
                    scan_clear    = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    if (res.free_found) begin
                        wr_en                    = 1'b1;
                        valid_next[res.free_idx] = 1'b1;
                        resident_next            = need_bytes[BYTES_W-1:0];
                    end
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_tready) begin
                    req_next     = req_reg + BYTES_W'(1);
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, hits_reg, req_next, resident_reg, evc_reg};
                    m_user_next  = {byp_reg, hit_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            cap_reg      <= '0;
            resident_reg <= '0;
            req_reg      <= '0;
            hits_reg     <= '0;
            valid_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            chk_vld_reg  <= chk_vld_next;
            cap_reg      <= cap_next;
            resident_reg <= resident_next;
            req_reg      <= req_next;
            hits_reg     <= hits_next;
            valid_reg    <= valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        chk_idx_reg <= chk_idx_next;
        key_reg     <= key_next;
        size_reg    <= size_next;
        nu_reg      <= nu_next;
        evc_reg     <= evc_next;
        hit_reg     <= hit_next;
        byp_reg     <= byp_next;
        m_data_reg  <= m_data_next;
        m_user_reg  <= m_user_next;
    end

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a request is in progress");

    a_hit_not_bypassed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result flagged both hit and bypassed");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata[EVC_W-1:0] == '0)
        else $error("hit or bypass reported evictions");

    a_scan_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_clear |-> !chk_vld_reg)
        else $error("scan restarted with a read still in flight");

endmodule

`default_nettype wire

// ===== dv/size_aware_min_cache_replacement_top_tb.sv =====
`timescale 1ns / 1ps

module size_aware_min_cache_replacement_top_tb;
    import sacr_pkg::*;

    localparam logic [NU_W-1:0]    NEVER       = 31'h7FFF_FFFF;
    localparam logic [BYTES_W-1:0] CAP_MAX     = 40'hFF_FFFF_FFFF;
    localparam int                 STALL_LIMIT = 400000;
    localparam int                 HOLD_CYCLES = 2000;
    localparam int                 DRAIN_CYCLES = 600;

    typedef struct packed {
        logic               hit;
        logic               bypassed;
        logic [EVC_W-1:0]   evicted;
        logic [BYTES_W-1:0] bytes_used;
        logic [BYTES_W-1:0] requests;
        logic [BYTES_W-1:0] hits;
    } outcome_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [BYTES_W-1:0]  cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic [USER_W-1:0]   m_tuser;

    // cache model
    bit                  cache_valid [ENTRIES];
    bit [KEY_W-1:0]      cache_key   [ENTRIES];
    bit [SIZE_W-1:0]     cache_obj_len [ENTRIES];
    bit [NU_W-1:0]       cache_next  [ENTRIES];
    bit [BYTES_W-1:0]    cache_bytes;
    bit [BYTES_W-1:0]    request_count;
    bit [BYTES_W-1:0]    hit_count;
    bit [BYTES_W-1:0]    capacity;

    outcome_t            pending_outcomes[$];
    int                  error_count;
    bit                  tx_gaps;
    bit                  rx_gaps;
    bit                  hold_request;

    size_aware_min_cache_replacement_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 80);
        end
    endfunction

    function automatic outcome_t predict_request(input logic [KEY_W-1:0] key,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic [NU_W-1:0] nu);
        outcome_t o;
        int       i;
        int       found;
        int       free_slot;
        int       victim;
        int       evictions;
        o = '0;
        found = -1;
        evictions = 0;
        for (i = 0; i < ENTRIES; i++) begin
            if (found < 0 && cache_valid[i] && cache_key[i] == key) found = i;
        end
        if (found >= 0) begin
            o.hit = 1'b1;
            cache_next[found] = nu;
            hit_count = hit_count + 1'b1;
        end else if ({9'b0, size} > capacity) begin
            o.bypassed = 1'b1;
        end else begin
            free_slot = -1;
            for (i = 0; i < ENTRIES; i++) begin
                if (free_slot < 0 && !cache_valid[i]) free_slot = i;
            end
            while (({1'b0, cache_bytes} + 41'(size)) > {1'b0, capacity} || free_slot < 0) begin
                // farthest next use, lowest slot on a tie
                victim = -1;
                for (i = 0; i < ENTRIES; i++) begin
                    if (cache_valid[i] && (victim < 0 || cache_next[i] > cache_next[victim]))
                        victim = i;
                end
                if (victim < 0) break;
                cache_bytes = cache_bytes - cache_obj_len[victim];
                cache_valid[victim] = 1'b0;
                evictions++;
                if (free_slot < 0 || victim < free_slot) free_slot = victim;
            end
            if (free_slot >= 0) begin
                cache_valid[free_slot] = 1'b1;
                cache_key[free_slot] = key;
                cache_obj_len[free_slot] = size;
                cache_next[free_slot] = nu;
                cache_bytes = cache_bytes + size;
            end
        end
        request_count = request_count + 1'b1;
        o.evicted = evictions[EVC_W-1:0];
        o.bytes_used = cache_bytes;
        o.requests = request_count;
        o.hits = hit_count;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTES_W-1:0] got,
                                   input logic [BYTES_W-1:0] exp);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
        error_count++;
    endtask

    task automatic check_result();
        outcome_t got;
        outcome_t exp;
        got.hit        = m_tuser[0];
        got.bypassed   = m_tuser[1];
        got.evicted    = m_tdata[8:0];
        got.bytes_used = m_tdata[48:9];
        got.requests   = m_tdata[88:49];
        got.hits       = m_tdata[128:89];
        if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected item, requests", got.requests, '0);
        end else begin
            exp = pending_outcomes.pop_front();
            if (got.hit !== exp.hit)
                report_mismatch("hit", BYTES_W'(got.hit), BYTES_W'(exp.hit));
            if (got.bypassed !== exp.bypassed)
                report_mismatch("bypassed", BYTES_W'(got.bypassed), BYTES_W'(exp.bypassed));
            if (got.evicted !== exp.evicted)
                report_mismatch("evicted_count", BYTES_W'(got.evicted), BYTES_W'(exp.evicted));
            if (got.bytes_used !== exp.bytes_used)
                report_mismatch("bytes_used", got.bytes_used, exp.bytes_used);
            if (got.requests !== exp.requests)
                report_mismatch("total_requests", got.requests, exp.requests);
            if (got.hits !== exp.hits) report_mismatch("hit_total", got.hits, exp.hits);
        end
    endtask

    task automatic send_request(input logic [KEY_W-1:0] key, input logic [SIZE_W-1:0] size,
                                input logic [NU_W-1:0] nu);
        int       gap;
        outcome_t expected;
        gap = tx_gaps ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, nu, size, key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected = predict_request(key, size, nu);
        pending_outcomes = {pending_outcomes, expected};
    endtask

    // stop offering items and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [BYTES_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        capacity = value;
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        logic [BYTES_W-1:0] lim;
        int                 r;
        r = $urandom_range(0, 9);
        lim = capacity / 16;
        if (lim > 40'h7FFF_FFFF) lim = 40'h7FFF_FFFF;
        if (r == 0) return SIZE_W'($urandom);
        if (r == 1) return '0;
        return SIZE_W'($urandom_range(0, lim[31:0]));
    endfunction

    function automatic logic [NU_W-1:0] pick_next_use();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return NEVER;
        if (r == 1) return NU_W'($urandom_range(0, 15));
        return NU_W'($urandom);
    endfunction

    task automatic test_directed();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        set_capacity('0);
        send_request(32'h0000_0000, 31'd0, 31'd5);          // zero size fits at zero capacity
        send_request(32'hFFFF_FFFF, 31'd1, 31'd9);          // bypass
        send_request(32'h0000_0000, 31'h7FFF_FFFF, NEVER);  // hit with different size
        set_capacity(40'd100);
        send_request(32'd1, 31'd60, 31'd10);
        send_request(32'd2, 31'd40, 31'd10);
        send_request(32'd3, 31'd101, 31'd0);                // one byte over capacity
        send_request(32'd4, 31'd30, 31'd3);                 // zero-size victim, then a tie
        send_request(32'd2, 31'd5, NEVER);
        send_request(32'd5, 31'd100, 31'd0);                // exactly capacity
        set_capacity(CAP_MAX);
        send_request(32'd6, 31'h7FFF_FFFF, 31'h7FFF_FFFE);
        send_request(32'd7, 31'h7FFF_FFFF, 31'd0);
        send_request(32'hAAAA_AAAA, 31'h5555_5555, 31'h2AAA_AAAA);
        send_request(32'h5555_5555, 31'h2AAA_AAAA, 31'h5555_5555);
        set_capacity(40'd10);                               // below resident bytes
        send_request(32'd7, 31'd0, 31'd1);
        send_request(32'd10, 31'd4, 31'd2);
        set_capacity('0);
        send_request(32'd11, 31'd0, 31'd0);
        send_request(32'd12, 31'd1, 31'd1);
    endtask

    // fill every slot, overflow the table, then evict nearly everything at once
    task automatic test_table_full();
        int i;
        tx_gaps = 1'b0;
        rx_gaps = 1'b1;
        set_capacity(CAP_MAX);
        for (i = 0; i < ENTRIES + 4; i++)
            send_request($urandom, SIZE_W'($urandom_range(1, 1000)), pick_next_use());
        set_capacity('0);
        send_request($urandom, '0, pick_next_use());
        set_capacity(40'd50000);
    endtask

    task automatic test_input_stall();
        int i;
        drain_results();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        hold_request = 1'b1;
        for (i = 0; i < 12; i++) send_request($urandom, pick_size(), pick_next_use());
    endtask

    task automatic test_random_traffic();
        logic [KEY_W-1:0] key_pool [64];
        int               pool_n;
        int               phase;
        int               i;
        logic [KEY_W-1:0] key;
        for (phase = 0; phase < 14; phase++) begin
            case ($urandom_range(0, 5))
                0: set_capacity('0);
                1: set_capacity(CAP_MAX);
                2: set_capacity(BYTES_W'($urandom_range(1, 5000)));
                3: set_capacity(BYTES_W'($urandom_range(5000, 32'h8000_0000)));
                4: set_capacity({8'($urandom_range(0, 255)), 32'($urandom)});
                default: set_capacity(cache_bytes / 2);
            endcase
            tx_gaps = $urandom_range(0, 3) != 0;
            rx_gaps = $urandom_range(0, 3) != 0;
            pool_n = $urandom_range(8, 48);
            for (i = 0; i < 64; i++) key_pool[i] = $urandom;
            for (i = 0; i < 100; i++) begin
                if ($urandom_range(0, 19) == 0) key = $urandom;
                else key = key_pool[$urandom_range(0, pool_n - 1)];
                send_request(key, pick_size(), pick_next_use());
            end
        end
    endtask

    // result side: stalls, long hold-off and checking
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) check_result();
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                hold_left = idle_len();
                m_tready <= (hold_left == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        error_count = 0;
        hold_request = 1'b0;
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_table_full();
        test_input_stall();
        test_random_traffic();
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && pending_outcomes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sacr_pkg.sv
rtl/sacr_ram.sv
rtl/sacr_scan.sv
rtl/size_aware_min_cache_replacement_top.sv
dv/size_aware_min_cache_replacement_top_tb.sv
